@@ hw/rtl/swarq_pkg.sv @@
`default_nettype none

package swarq_pkg;

   // fixed field widths
   localparam int FLAGS_BITS     = 8;
   localparam int TAG_BITS       = 8;
   localparam int RETRY_BITS     = 8;
   localparam int TIMEOUT_BITS   = 32;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 64;

   // register reset values
   localparam logic [TIMEOUT_BITS-1:0] ACK_TIMEOUT_RESET = 32'd5000;
   localparam logic [RETRY_BITS-1:0]   RETRY_LIMIT_RESET = 8'd5;

   // input commands
   typedef enum logic [1:0] {
      CMD_SEND  = 2'd0,
      CMD_FRAME = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_RESET = 2'd3
   } cmd_type;

   // received frame kinds
   typedef enum logic [1:0] {
      FRM_DATA  = 2'd0,
      FRM_ACK   = 2'd1,
      FRM_NAK   = 2'd2,
      FRM_OTHER = 2'd3
   } frame_kind_type;

   // result events
   typedef enum logic [2:0] {
      EV_TX_DATA     = 3'd0,
      EV_TX_ACK      = 3'd1,
      EV_TX_NAK      = 3'd2,
      EV_DELIVER     = 3'd3,
      EV_SEND_OK     = 3'd4,
      EV_SEND_FAILED = 3'd5,
      EV_SEND_REJECT = 3'd6
   } event_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ACK_TIMEOUT    = 8'd0,
      CSR_RETRY_LIMIT    = 8'd1,
      CSR_LOCAL_ADDRESS  = 8'd2,
      CSR_REMOTE_ADDRESS = 8'd3
   } csr_index_type;

endpackage

`default_nettype wire

@@ hw/rtl/swarq_req_if.sv @@
`default_nettype none

interface swarq_req_if #(
   parameter int SEQ_BITS  = 8,
   parameter int ADDR_BITS = 48
) ();
   import swarq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              command;
   logic [1:0]              frame_type;
   logic [SEQ_BITS-1:0]     sequence_req;
   logic [FLAGS_BITS-1:0]   frame_flags;
   logic [ADDR_BITS-1:0]    dest_address;
   logic [ADDR_BITS-1:0]    source_address;
   logic [TIMEOUT_BITS-1:0] tick_ms;
   logic [TAG_BITS-1:0]     buffer_tag;

   modport source (
      output valid, command, frame_type, sequence_req, frame_flags,
             dest_address, source_address, tick_ms, buffer_tag,
      input  ready
   );

   modport sink (
      input  valid, command, frame_type, sequence_req, frame_flags,
             dest_address, source_address, tick_ms, buffer_tag,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/swarq_rsp_if.sv @@
`default_nettype none

interface swarq_rsp_if #(
   parameter int SEQ_BITS  = 8,
   parameter int ADDR_BITS = 48
) ();
   import swarq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [2:0]            event_res;
   logic [SEQ_BITS-1:0]   out_sequence;
   logic [FLAGS_BITS-1:0] out_flags;
   logic [ADDR_BITS-1:0]  out_address;
   logic [TAG_BITS-1:0]   out_tag;
   logic                  last;

   modport source (
      output valid, event_res, out_sequence, out_flags, out_address, out_tag, last,
      input  ready
   );

   modport sink (
      input  valid, event_res, out_sequence, out_flags, out_address, out_tag, last,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/swarq_csr_if.sv @@
`default_nettype none

interface swarq_csr_if ();
   import swarq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/stop_and_wait_arq_engine_unit.sv @@
`default_nettype none

// Stop-and-wait ARQ engine. Each item on req_ch is one event (send request,
// received frame header, millisecond tick or protocol reset) and gives zero,
// one or two items on rsp_ch; last marks the final one. An item is taken
// into an input register, decided by the compare/update logic against the
// protocol state once the output register is free, and its results land in
// a two-entry output register, from which the first result is offered. A new
// item is accepted every cycle while each gives at most one result and
// rsp_ch is ready; in-order data (deliver followed by ack) holds the output
// register until the ack is taken, and no new item is decided before then.
// Configuration writes on csr_ch are always accepted and take effect on the
// next cycle; write them only while no item is in flight.
module stop_and_wait_arq_engine_unit #(
   parameter int SEQ_BITS  = 8,
   parameter int ADDR_BITS = 48
) (
   input  wire logic     clock,
   input  wire logic     reset,
   swarq_req_if.sink     req_ch,
   swarq_rsp_if.source   rsp_ch,
   swarq_csr_if.sink     csr_ch
);
   import swarq_pkg::*;

   // configuration registers
   logic [TIMEOUT_BITS-1:0] ack_timeout_ff;
   logic [RETRY_BITS-1:0]   retry_limit_ff;
   logic [ADDR_BITS-1:0]    local_addr_ff;
   logic [ADDR_BITS-1:0]    remote_addr_ff;

   // input register
   logic                    in_valid_ff;
   cmd_type                 in_cmd_ff;
   frame_kind_type          in_kind_ff;
   logic [SEQ_BITS-1:0]     in_seq_ff;
   logic [FLAGS_BITS-1:0]   in_flags_ff;
   logic [ADDR_BITS-1:0]    in_dest_ff;
   logic [ADDR_BITS-1:0]    in_src_ff;
   logic [TIMEOUT_BITS-1:0] in_elapsed_ff;
   logic [TAG_BITS-1:0]     in_tag_ff;

   // output register, entry 0 is shown
   logic [1:0]              ob_cnt_ff;
   event_type               ob0_event_ff, ob1_event_ff;
   logic [SEQ_BITS-1:0]     ob0_seq_ff,   ob1_seq_ff;
   logic [FLAGS_BITS-1:0]   ob0_flags_ff;
   logic [ADDR_BITS-1:0]    ob0_addr_ff,  ob1_addr_ff;
   logic [TAG_BITS-1:0]     ob0_tag_ff;

   // decision results
   logic [1:0]              res_count;
   event_type               res0_event, res1_event;
   logic [SEQ_BITS-1:0]     res0_seq,   res1_seq;
   logic [FLAGS_BITS-1:0]   res0_flags;
   logic [ADDR_BITS-1:0]    res0_addr,  res1_addr;
   logic [TAG_BITS-1:0]     res0_tag;

   logic req_acc;
   logic rsp_acc;
   logic ob_free;
   logic fire;

   assign csr_ch.ready = 1'b1;
   assign rsp_acc      = rsp_ch.valid && rsp_ch.ready;
   assign ob_free      = (ob_cnt_ff == 2'd0) || (rsp_acc && ob_cnt_ff == 2'd1);
   assign fire         = in_valid_ff && ob_free;
   assign req_ch.ready = !in_valid_ff || fire;
   assign req_acc      = req_ch.valid && req_ch.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
         retry_limit_ff <= RETRY_LIMIT_RESET;
         local_addr_ff  <= '0;
         remote_addr_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_ACK_TIMEOUT:    ack_timeout_ff <= csr_ch.data[TIMEOUT_BITS-1:0];
            CSR_RETRY_LIMIT:    retry_limit_ff <= csr_ch.data[RETRY_BITS-1:0];
            CSR_LOCAL_ADDRESS:  local_addr_ff  <= csr_ch.data[ADDR_BITS-1:0];
            CSR_REMOTE_ADDRESS: remote_addr_ff <= csr_ch.data[ADDR_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_acc) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_cmd_ff     <= cmd_type'(req_ch.command);
         in_kind_ff    <= frame_kind_type'(req_ch.frame_type);
         in_seq_ff     <= req_ch.sequence_req;
         in_flags_ff   <= req_ch.frame_flags;
         in_dest_ff    <= req_ch.dest_address;
         in_src_ff     <= req_ch.source_address;
         in_elapsed_ff <= req_ch.tick_ms;
         in_tag_ff     <= req_ch.buffer_tag;
      end
   end

   swarq_core #(
      .SEQ_BITS  (SEQ_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .cmd         (in_cmd_ff),
      .kind        (in_kind_ff),
      .seq         (in_seq_ff),
      .flags       (in_flags_ff),
      .dest        (in_dest_ff),
      .src         (in_src_ff),
      .elapsed     (in_elapsed_ff),
      .tag         (in_tag_ff),
      .ack_timeout (ack_timeout_ff),
      .retry_limit (retry_limit_ff),
      .local_addr  (local_addr_ff),
      .remote_addr (remote_addr_ff),
      .res_count   (res_count),
      .res0_event  (res0_event),
      .res0_seq    (res0_seq),
      .res0_flags  (res0_flags),
      .res0_addr   (res0_addr),
      .res0_tag    (res0_tag),
      .res1_event  (res1_event),
      .res1_seq    (res1_seq),
      .res1_addr   (res1_addr)
   );

   // output register count
   always_ff @(posedge clock) begin
      if (reset) begin
         ob_cnt_ff <= 2'd0;
      end else if (fire) begin
         ob_cnt_ff <= res_count;
      end else if (rsp_acc) begin
         ob_cnt_ff <= ob_cnt_ff - 2'd1;
      end
   end

   // output register payload: load on fire, shift after the first is taken
   always_ff @(posedge clock) begin
      if (fire) begin
         ob0_event_ff <= res0_event;
         ob0_seq_ff   <= res0_seq;
         ob0_flags_ff <= res0_flags;
         ob0_addr_ff  <= res0_addr;
         ob0_tag_ff   <= res0_tag;
         ob1_event_ff <= res1_event;
         ob1_seq_ff   <= res1_seq;
         ob1_addr_ff  <= res1_addr;
      end else if (rsp_acc && ob_cnt_ff == 2'd2) begin
         ob0_event_ff <= ob1_event_ff;
         ob0_seq_ff   <= ob1_seq_ff;
         ob0_flags_ff <= '0;
         ob0_addr_ff  <= ob1_addr_ff;
         ob0_tag_ff   <= '0;
      end
   end

   assign rsp_ch.valid        = (ob_cnt_ff != 2'd0);
   assign rsp_ch.last         = (ob_cnt_ff == 2'd1);
   assign rsp_ch.event_res    = ob0_event_ff;
   assign rsp_ch.out_sequence = ob0_seq_ff;
   assign rsp_ch.out_flags    = ob0_flags_ff;
   assign rsp_ch.out_address  = ob0_addr_ff;
   assign rsp_ch.out_tag      = ob0_tag_ff;

`ifndef SYNTHESIS
   // a non-final result is always followed by another one
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && !rsp_ch.last) |=> rsp_ch.valid)
      else $error("second result missing after non-final result");

   // once the final result is taken with nothing new decided, output goes idle
   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_ch.last && !fire) |=> !rsp_ch.valid)
      else $error("result shown with no item decided");

   // two results only come from in-order data delivery
   a_pair_is_deliver: assert property (@(posedge clock) disable iff (reset)
      (fire && res_count == 2'd2) |-> (res0_event == EV_DELIVER && res1_event == EV_TX_ACK))
      else $error("result pair is not deliver plus ack");

   // the output register never holds more than two results
   a_ob_bound: assert property (@(posedge clock) disable iff (reset)
      fire |=> (ob_cnt_ff != 2'd3))
      else $error("output register overfilled");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/swarq_core.sv @@
`default_nettype none

// protocol state and per-item decision; state advances when fire is high
module swarq_core #(
   parameter int SEQ_BITS  = 8,
   parameter int ADDR_BITS = 48
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              fire,
   // item under decision
   input  wire swarq_pkg::cmd_type                cmd,
   input  wire swarq_pkg::frame_kind_type         kind,
   input  wire logic [SEQ_BITS-1:0]               seq,
   input  wire logic [swarq_pkg::FLAGS_BITS-1:0]  flags,
   input  wire logic [ADDR_BITS-1:0]              dest,
   input  wire logic [ADDR_BITS-1:0]              src,
   input  wire logic [swarq_pkg::TIMEOUT_BITS-1:0] elapsed,
   input  wire logic [swarq_pkg::TAG_BITS-1:0]    tag,
   // configuration
   input  wire logic [swarq_pkg::TIMEOUT_BITS-1:0] ack_timeout,
   input  wire logic [swarq_pkg::RETRY_BITS-1:0]  retry_limit,
   input  wire logic [ADDR_BITS-1:0]              local_addr,
   input  wire logic [ADDR_BITS-1:0]              remote_addr,
   // results of the item
   output logic [1:0]                             res_count,
   output swarq_pkg::event_type                   res0_event,
   output logic [SEQ_BITS-1:0]                    res0_seq,
   output logic [swarq_pkg::FLAGS_BITS-1:0]       res0_flags,
   output logic [ADDR_BITS-1:0]                   res0_addr,
   output logic [swarq_pkg::TAG_BITS-1:0]         res0_tag,
   output swarq_pkg::event_type                   res1_event,
   output logic [SEQ_BITS-1:0]                    res1_seq,
   output logic [ADDR_BITS-1:0]                   res1_addr
);
   import swarq_pkg::*;

   logic                    waiting_ff,  waiting_in;
   logic [SEQ_BITS-1:0]     tx_seq_ff,   tx_seq_in;
   logic [SEQ_BITS-1:0]     rx_exp_ff,   rx_exp_in;
   logic [RETRY_BITS-1:0]   retry_ff,    retry_in;
   logic [TIMEOUT_BITS-1:0] timeout_ff,  timeout_in;
   logic [FLAGS_BITS-1:0]   pend_flags_ff, pend_flags_in;
   logic [TAG_BITS-1:0]     pend_tag_ff,   pend_tag_in;

   logic [RETRY_BITS-1:0]   retry_inc;
   logic                    retry_out;
   logic                    for_us;
   logic                    do_retry;

   assign retry_inc = retry_ff + 1'b1;
   assign retry_out = (retry_inc >= retry_limit);
   assign for_us    = (dest == local_addr);

   // decision logic
   always_comb begin
      waiting_in    = waiting_ff;
      tx_seq_in     = tx_seq_ff;
      rx_exp_in     = rx_exp_ff;
      retry_in      = retry_ff;
      timeout_in    = timeout_ff;
      pend_flags_in = pend_flags_ff;
      pend_tag_in   = pend_tag_ff;
      do_retry      = 1'b0;

      res_count  = 2'd0;
      res0_event = EV_SEND_REJECT;
      res0_seq   = '0;
      res0_flags = '0;
      res0_addr  = '0;
      res0_tag   = '0;
      res1_event = EV_TX_ACK;
      res1_seq   = seq;
      res1_addr  = src;

      case (cmd)
         CMD_SEND: begin
            res_count = 2'd1;
            if (!(waiting_ff || local_addr == '0 || remote_addr == '0)) begin
               pend_flags_in = flags;
               pend_tag_in   = tag;
               retry_in      = '0;
               waiting_in    = 1'b1;
               timeout_in    = ack_timeout;
               res0_event    = EV_TX_DATA;
               res0_seq      = tx_seq_ff;
               res0_flags    = flags;
               res0_addr     = remote_addr;
               res0_tag      = tag;
            end
         end
         CMD_FRAME: begin
            if (for_us) begin
               case (kind)
                  FRM_DATA: begin
                     res_count = 2'd1;
                     res0_addr = src;
                     if (seq == rx_exp_ff) begin
                        // in order: deliver, then ack
                        res_count  = 2'd2;
                        res0_event = EV_DELIVER;
                        res0_seq   = seq;
                        res0_flags = flags;
                        res0_addr  = '0;
                        res0_tag   = tag;
                        rx_exp_in  = rx_exp_ff + 1'b1;
                     end else if (seq == rx_exp_ff - 1'b1) begin
                        res0_event = EV_TX_ACK;
                        res0_seq   = seq;
                     end else begin
                        res0_event = EV_TX_NAK;
                        res0_seq   = rx_exp_ff;
                     end
                  end
                  FRM_ACK: begin
                     if (waiting_ff && seq == tx_seq_ff) begin
                        res_count  = 2'd1;
                        res0_event = EV_SEND_OK;
                        res0_seq   = tx_seq_ff;
                        tx_seq_in  = tx_seq_ff + 1'b1;
                        waiting_in = 1'b0;
                     end
                  end
                  FRM_NAK: begin
                     do_retry = waiting_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         CMD_TICK: begin
            if (waiting_ff) begin
               if (elapsed >= timeout_ff) begin
                  do_retry = 1'b1;
               end else begin
                  timeout_in = timeout_ff - elapsed;
               end
            end
         end
         default: begin
            waiting_in = 1'b0;
            tx_seq_in  = '0;
            rx_exp_in  = '0;
            retry_in   = '0;
            timeout_in = '0;
         end
      endcase

      // retransmit or give up
      if (do_retry) begin
         res_count = 2'd1;
         retry_in  = retry_inc;
         res0_seq  = tx_seq_ff;
         if (retry_out) begin
            res0_event = EV_SEND_FAILED;
            waiting_in = 1'b0;
            tx_seq_in  = tx_seq_ff + 1'b1;
         end else begin
            res0_event = EV_TX_DATA;
            res0_flags = pend_flags_ff;
            res0_addr  = remote_addr;
            res0_tag   = pend_tag_ff;
            timeout_in = ack_timeout;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b0;
         tx_seq_ff  <= '0;
         rx_exp_ff  <= '0;
         retry_ff   <= '0;
         timeout_ff <= '0;
      end else if (fire) begin
         waiting_ff <= waiting_in;
         tx_seq_ff  <= tx_seq_in;
         rx_exp_ff  <= rx_exp_in;
         retry_ff   <= retry_in;
         timeout_ff <= timeout_in;
      end
   end

   // pending send descriptor
   always_ff @(posedge clock) begin
      if (fire) begin
         pend_flags_ff <= pend_flags_in;
         pend_tag_ff   <= pend_tag_in;
      end
   end

endmodule

`default_nettype wire
